>>> rtl/pac_pkg.sv
package pac_pkg;

    localparam int FRAC_BITS = 16;
    // dividend is |diff| (33 bits) shifted up by the fraction bits
    localparam int DIV_W     = 33 + FRAC_BITS;
    localparam int MUL_STEPS = 32;
    localparam int CNT_W     = $clog2(DIV_W + 1);

    typedef enum logic [1:0] {
        MODE_UPDATE   = 2'd0,
        MODE_RESET    = 2'd1,
        MODE_ARM      = 2'd2,
        MODE_RESERVED = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_SAT       = 2'd1,
        ST_NOT_ARMED = 2'd2,
        ST_INVALID   = 2'd3
    } status_t;

    typedef enum logic {
        OP_MUL = 1'b0,
        OP_DIV = 1'b1
    } mdu_op_t;

    typedef struct packed {
        logic    start;
        mdu_op_t op;
        logic    neg;
    } mdu_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } mdu_stat_t;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [31:0] r;
        if (v[65:31] != {35{v[65]}})
            r = v[65] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

>>> rtl/pac_mdu.sv
module pac_mdu (
    input  logic                    clk,
    input  logic                    rst_n,
    input  pac_pkg::mdu_req_t       req,
    input  logic signed [31:0]      a,
    input  logic        [31:0]      b,
    input  logic signed [32:0]      diff,
    output pac_pkg::mdu_stat_t      stat,
    output logic signed [31:0]      result
);

    localparam logic [pac_pkg::CNT_W-1:0] MUL_LAST =
        pac_pkg::CNT_W'(pac_pkg::MUL_STEPS - 1);
    localparam logic [pac_pkg::CNT_W-1:0] DIV_LAST =
        pac_pkg::CNT_W'(pac_pkg::DIV_W - 1);

    logic                          busy_reg;
    logic                          done_reg;
    pac_pkg::mdu_op_t              op_reg;
    logic                          neg_reg;
    logic [pac_pkg::CNT_W-1:0]     cnt_reg;
    logic signed [63:0]            acc_reg;
    logic [63:0]                   mcand_reg;
    logic [31:0]                   mplier_reg;
    logic [31:0]                   rem_reg;
    logic [pac_pkg::DIV_W-1:0]     quo_reg;

    logic [32:0]                   mag;
    logic [32:0]                   sh;
    logic [32:0]                   trial;
    logic                          ge;
    logic signed [63:0]            shv;
    logic signed [65:0]            mul_ext;
    logic signed [65:0]            div_ext;
    logic [pac_pkg::CNT_W-1:0]     last;

    assign mag   = diff[32] ? 33'(-diff) : 33'(diff);
    assign sh    = {rem_reg, quo_reg[pac_pkg::DIV_W-1]};
    assign trial = sh - {1'b0, mplier_reg};
    assign ge    = sh >= {1'b0, mplier_reg};
    assign last  = (op_reg == pac_pkg::OP_MUL) ? MUL_LAST : DIV_LAST;

    // floor shift of the product, then optional negation
    assign shv     = acc_reg >>> pac_pkg::FRAC_BITS;
    assign mul_ext = neg_reg ? -{{2{shv[63]}}, shv} : {{2{shv[63]}}, shv};
    assign div_ext = neg_reg ? -$signed({{(66 - pac_pkg::DIV_W){1'b0}}, quo_reg})
                             :  $signed({{(66 - pac_pkg::DIV_W){1'b0}}, quo_reg});

    assign result = (op_reg == pac_pkg::OP_MUL) ? pac_pkg::sat32(mul_ext)
                                                : pac_pkg::sat32(div_ext);
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            op_reg   <= pac_pkg::OP_MUL;
            neg_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                op_reg   <= req.op;
                if (req.op == pac_pkg::OP_MUL)
                begin
                    neg_reg    <= req.neg;
                    acc_reg    <= '0;
                    mcand_reg  <= {{32{a[31]}}, a};
                    mplier_reg <= b;
                end
                else
                begin
                    neg_reg    <= diff[32];
                    rem_reg    <= '0;
                    quo_reg    <= {mag, {pac_pkg::FRAC_BITS{1'b0}}};
                    mplier_reg <= b;
                end
            end
            else if (busy_reg)
            begin
                if (op_reg == pac_pkg::OP_MUL)
                begin
                    if (mplier_reg[0])
                        acc_reg <= acc_reg + $signed(mcand_reg);
                    mcand_reg  <= {mcand_reg[62:0], 1'b0};
                    mplier_reg <= {1'b0, mplier_reg[31:1]};
                end
                else
                begin
                    rem_reg <= ge ? trial[31:0] : sh[31:0];
                    quo_reg <= {quo_reg[pac_pkg::DIV_W-2:0], ge};
                end
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == last)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

>>> rtl/pid_antiwindup_controller.sv
// Update with measurement history: four multiplies and a divide on one shared unit,
// each with its hand-off, then a commit step and a register step.
// Update without history: three multiplies, then the commit and register steps;
// other modes and rejected updates go straight to the register step.
// One request at a time: the next is taken the cycle after the result is registered.
// Reset (asynchronous, active low) clears integrator and history, disarms,
// and loads the register reset values into registers and snapshot.
module pid_antiwindup_controller (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         mode,
    input  logic signed [31:0] setpoint,
    input  logic signed [31:0] measurement,
    input  logic [31:0]        dt,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] command,
    output logic [1:0]         status,
    output logic signed [31:0] integrator
);

    typedef enum logic [2:0] {
        REG_KP   = 3'd0,
        REG_KI   = 3'd1,
        REG_KD   = 3'd2,
        REG_OMIN = 3'd3,
        REG_OMAX = 3'd4,
        REG_IMIN = 3'd5,
        REG_IMAX = 3'd6,
        REG_MDT  = 3'd7
    } reg_idx_t;

    typedef enum logic [2:0] {
        S_IDLE, S_P, S_KI, S_DT, S_DIV, S_KD, S_FIN, S_EMIT
    } state_t;

    localparam logic signed [31:0] LIM_RST = 32'sd1 <<< pac_pkg::FRAC_BITS;

    logic [30:0]        kp_reg, ki_reg, kd_reg;
    logic signed [31:0] omin_reg, omax_reg, imin_reg, imax_reg;
    logic [31:0]        mdt_reg;

    logic [30:0]        sn_kp_reg, sn_ki_reg, sn_kd_reg;
    logic signed [31:0] sn_omin_reg, sn_omax_reg, sn_imin_reg, sn_imax_reg;

    state_t             state_reg;
    logic signed [31:0] acc_reg;
    logic signed [31:0] last_meas_reg;
    logic               hist_reg;
    logic               armed_reg;
    logic signed [31:0] err_reg;
    logic signed [31:0] meas_reg;
    logic [31:0]        dt_reg;
    logic signed [31:0] p_reg, step_reg, d_reg;
    logic signed [31:0] res_cmd_reg;
    pac_pkg::status_t   res_status_reg;
    logic               out_valid_reg;
    logic signed [31:0] out_cmd_reg;
    logic [1:0]         out_status_reg;
    logic signed [31:0] out_int_reg;

    pac_pkg::mdu_req_t  req_reg;
    logic signed [31:0] op_a_reg;
    logic [31:0]        op_b_reg;
    pac_pkg::mdu_stat_t mdu_stat;
    logic signed [31:0] mdu_res;

    logic               wr_en;
    logic signed [32:0] err_wide;
    logic signed [31:0] err_now;
    logic               cfg_ok;
    logic signed [32:0] diff;
    logic signed [32:0] sum1;
    logic signed [31:0] cand;
    logic signed [33:0] unsat;
    logic signed [31:0] cmd_c;
    logic               push_max, push_min;
    logic               accept;

    assign pready   = 1'b1;
    assign wr_en    = psel & penable & pwrite & pready;
    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid & in_ready;

    assign out_valid  = out_valid_reg;
    assign command    = out_cmd_reg;
    assign status     = out_status_reg;
    assign integrator = out_int_reg;

    always_comb
    begin
        unique case (reg_idx_t'(paddr[4:2]))
            REG_KP:   prdata = {1'b0, kp_reg};
            REG_KI:   prdata = {1'b0, ki_reg};
            REG_KD:   prdata = {1'b0, kd_reg};
            REG_OMIN: prdata = omin_reg;
            REG_OMAX: prdata = omax_reg;
            REG_IMIN: prdata = imin_reg;
            REG_IMAX: prdata = imax_reg;
            REG_MDT:  prdata = mdt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_reg   <= '0;
            ki_reg   <= '0;
            kd_reg   <= '0;
            omin_reg <= -LIM_RST;
            omax_reg <= LIM_RST;
            imin_reg <= -LIM_RST;
            imax_reg <= LIM_RST;
            mdt_reg  <= LIM_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_idx_t'(paddr[4:2]))
                REG_KP:   kp_reg   <= pwdata[30:0];
                REG_KI:   ki_reg   <= pwdata[30:0];
                REG_KD:   kd_reg   <= pwdata[30:0];
                REG_OMIN: omin_reg <= pwdata;
                REG_OMAX: omax_reg <= pwdata;
                REG_IMIN: imin_reg <= pwdata;
                REG_IMAX: imax_reg <= pwdata;
                REG_MDT:  mdt_reg  <= pwdata;
            endcase
        end
    end

    assign err_wide = {setpoint[31], setpoint} - {measurement[31], measurement};
    assign err_now  = pac_pkg::sat32({{33{err_wide[32]}}, err_wide});
    assign cfg_ok   = (omin_reg < omax_reg) && (imin_reg < imax_reg)
                      && (imin_reg <= 0) && (imax_reg >= 0);
    assign diff     = {meas_reg[31], meas_reg} - {last_meas_reg[31], last_meas_reg};

    // integrator candidate, then the unclamped and clamped command and the windup flags
    always_comb
    begin
        sum1 = {acc_reg[31], acc_reg} + {step_reg[31], step_reg};
        if (sum1 < $signed({sn_imin_reg[31], sn_imin_reg}))
            cand = sn_imin_reg;
        else if (sum1 > $signed({sn_imax_reg[31], sn_imax_reg}))
            cand = sn_imax_reg;
        else
            cand = sum1[31:0];
        unsat = {{2{p_reg[31]}}, p_reg} + {{2{cand[31]}}, cand}
                + {{2{d_reg[31]}}, d_reg};
        if (unsat < $signed({{2{sn_omin_reg[31]}}, sn_omin_reg}))
            cmd_c = sn_omin_reg;
        else if (unsat > $signed({{2{sn_omax_reg[31]}}, sn_omax_reg}))
            cmd_c = sn_omax_reg;
        else
            cmd_c = unsat[31:0];
        push_max = (unsat > $signed({{2{sn_omax_reg[31]}}, sn_omax_reg}))
                   && !err_reg[31] && (err_reg != 0);
        push_min = (unsat < $signed({{2{sn_omin_reg[31]}}, sn_omin_reg}))
                   && err_reg[31];
    end

    pac_mdu u_mdu (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req_reg),
        .a      (op_a_reg),
        .b      (op_b_reg),
        .diff   (diff),
        .stat   (mdu_stat),
        .result (mdu_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            acc_reg        <= '0;
            last_meas_reg  <= '0;
            hist_reg       <= 1'b0;
            armed_reg      <= 1'b0;
            sn_kp_reg      <= '0;
            sn_ki_reg      <= '0;
            sn_kd_reg      <= '0;
            sn_omin_reg    <= -LIM_RST;
            sn_omax_reg    <= LIM_RST;
            sn_imin_reg    <= -LIM_RST;
            sn_imax_reg    <= LIM_RST;
            req_reg        <= '0;
            out_valid_reg  <= 1'b0;
            res_status_reg <= pac_pkg::ST_OK;
        end
        else
        begin
            req_reg.start <= 1'b0;
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        res_cmd_reg <= '0;
                        meas_reg    <= measurement;
                        dt_reg      <= dt;
                        err_reg     <= err_now;
                        state_reg   <= S_EMIT;
                        unique case (pac_pkg::mode_t'(mode))
                            pac_pkg::MODE_ARM:
                            begin
                                if (cfg_ok)
                                begin
                                    sn_kp_reg      <= kp_reg;
                                    sn_ki_reg      <= ki_reg;
                                    sn_kd_reg      <= kd_reg;
                                    sn_omin_reg    <= omin_reg;
                                    sn_omax_reg    <= omax_reg;
                                    sn_imin_reg    <= imin_reg;
                                    sn_imax_reg    <= imax_reg;
                                    armed_reg      <= 1'b1;
                                    acc_reg        <= '0;
                                    last_meas_reg  <= '0;
                                    hist_reg       <= 1'b0;
                                    res_status_reg <= pac_pkg::ST_OK;
                                end
                                else
                                begin
                                    armed_reg      <= 1'b0;
                                    res_status_reg <= pac_pkg::ST_INVALID;
                                end
                            end
                            pac_pkg::MODE_RESET:
                            begin
                                acc_reg        <= '0;
                                last_meas_reg  <= '0;
                                hist_reg       <= 1'b0;
                                res_status_reg <= pac_pkg::ST_OK;
                            end
                            pac_pkg::MODE_RESERVED:
                                res_status_reg <= pac_pkg::ST_INVALID;
                            pac_pkg::MODE_UPDATE:
                            begin
                                if (!armed_reg)
                                    res_status_reg <= pac_pkg::ST_NOT_ARMED;
                                else if (dt == 0 || dt > mdt_reg)
                                    res_status_reg <= pac_pkg::ST_INVALID;
                                else
                                begin
                                    req_reg   <= '{start: 1'b1, op: pac_pkg::OP_MUL,
                                                   neg: 1'b0};
                                    op_a_reg  <= err_now;
                                    op_b_reg  <= {1'b0, sn_kp_reg};
                                    state_reg <= S_P;
                                end
                            end
                        endcase
                    end
                end
                S_P:
                begin
                    if (mdu_stat.done)
                    begin
                        p_reg     <= mdu_res;
                        req_reg   <= '{start: 1'b1, op: pac_pkg::OP_MUL, neg: 1'b0};
                        op_a_reg  <= err_reg;
                        op_b_reg  <= {1'b0, sn_ki_reg};
                        state_reg <= S_KI;
                    end
                end
                S_KI:
                begin
                    if (mdu_stat.done)
                    begin
                        req_reg   <= '{start: 1'b1, op: pac_pkg::OP_MUL, neg: 1'b0};
                        op_a_reg  <= mdu_res;
                        op_b_reg  <= dt_reg;
                        state_reg <= S_DT;
                    end
                end
                S_DT:
                begin
                    if (mdu_stat.done)
                    begin
                        step_reg <= mdu_res;
                        if (hist_reg)
                        begin
                            req_reg   <= '{start: 1'b1, op: pac_pkg::OP_DIV, neg: 1'b0};
                            op_b_reg  <= dt_reg;
                            state_reg <= S_DIV;
                        end
                        else
                        begin
                            d_reg     <= '0;
                            state_reg <= S_FIN;
                        end
                    end
                end
                S_DIV:
                begin
                    if (mdu_stat.done)
                    begin
                        // derivative acts against the measurement change
                        req_reg   <= '{start: 1'b1, op: pac_pkg::OP_MUL, neg: 1'b1};
                        op_a_reg  <= mdu_res;
                        op_b_reg  <= {1'b0, sn_kd_reg};
                        state_reg <= S_KD;
                    end
                end
                S_KD:
                begin
                    if (mdu_stat.done)
                    begin
                        d_reg     <= mdu_res;
                        state_reg <= S_FIN;
                    end
                end
                S_FIN:
                begin
                    if (!push_max && !push_min)
                        acc_reg <= cand;
                    last_meas_reg  <= meas_reg;
                    hist_reg       <= 1'b1;
                    res_cmd_reg    <= cmd_c;
                    res_status_reg <= ({{2{cmd_c[31]}}, cmd_c} != unsat) ?
                                      pac_pkg::ST_SAT : pac_pkg::ST_OK;
                    state_reg      <= S_EMIT;
                end
                S_EMIT:
                begin
                    // hold until the output slot is free
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_cmd_reg    <= res_cmd_reg;
                        out_status_reg <= res_status_reg;
                        out_int_reg    <= acc_reg;
                        state_reg      <= S_IDLE;
                    end
                end
            endcase
        end
    end

    a_ready_unit_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !mdu_stat.busy)
        else $error("request taken while arithmetic unit busy");

    a_disarm_by_arm: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(armed_reg) |-> $past(accept && mode == pac_pkg::MODE_ARM))
        else $error("disarmed without an arm request");

    a_hist_after_update: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(hist_reg) |-> $past(state_reg == S_FIN))
        else $error("history set outside an update");

    a_reject_zero_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_status_reg == pac_pkg::ST_NOT_ARMED
                           || out_status_reg == pac_pkg::ST_INVALID))
        |-> (out_cmd_reg == 0))
        else $error("rejected request carries a command");

endmodule
